### rtl/core/cdau_pkg.sv
// ----------------------------------------------------------------------------
// cdau_pkg
// Types, constants and small tables shared by the calendar date unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdau_pkg;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned DIV_QW     = 8;   // quotient bits per division
  localparam int unsigned DIV_NW     = 28;  // dividend width
  localparam int unsigned DIV_DW     = 21;  // divisor and reciprocal width
  localparam int unsigned DIV_RS     = 32;  // reciprocal scale, 2^32

  // floor(2^32 / divisor); estimate is exact or one low for dividends < 2^28
  localparam logic [20:0] RCP_N = 21'd29398;    // 146097
  localparam logic [20:0] RCP_I = 21'd2939;     // 1461001
  localparam logic [20:0] RCP_J = 21'd1755197;  // 2447

  localparam logic [13:0] RST_YEAR  = 14'd1959;
  localparam logic [3:0]  RST_MONTH = 4'd5;
  localparam logic [4:0]  RST_DAY   = 5'd11;

  localparam logic [13:0] LOAD_YEAR_MIN = 14'd1801;
  localparam logic [13:0] LOAD_YEAR_MAX = 14'd2099;

  localparam logic signed [25:0] JD_MIN = 26'sd1721426;
  localparam logic signed [25:0] JD_MAX = 26'sd5373484;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_LOAD  = 2'd1;
  localparam logic [1:0] STATUS_BAD_SHIFT = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SHIFT = 1'b1;

  typedef enum logic [1:0] {
    DIV_N,
    DIV_I,
    DIV_J
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHIFT,
    ST_N_GO,
    ST_N_WAIT,
    ST_I_GO,
    ST_I_WAIT,
    ST_J_GO,
    ST_J_WAIT,
    ST_JD_NOW,
    ST_JD_JAN,
    ST_JD_IN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     load;
    logic     shift;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_n;
    logic     take_i;
    logic     take_j;
    logic     jd_now;
    logic     jd_jan;
    logic     jd_in;
    logic     emit;
  } cdau_cmd_t;

  typedef struct packed {
    logic shift_bad;
    logic div_done;
  } cdau_stat_t;

  // 367 * (m - 2 - 12a) / 12, a = -1 for months up to February
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] v;
    begin
      unique case (m)
        4'd0:    v = 9'd305;
        4'd1:    v = 9'd336;
        4'd2:    v = 9'd367;
        4'd3:    v = 9'd30;
        4'd4:    v = 9'd61;
        4'd5:    v = 9'd91;
        4'd6:    v = 9'd122;
        4'd7:    v = 9'd152;
        4'd8:    v = 9'd183;
        4'd9:    v = 9'd214;
        4'd10:   v = 9'd244;
        4'd11:   v = 9'd275;
        4'd12:   v = 9'd305;
        4'd13:   v = 9'd336;
        4'd14:   v = 9'd367;
        default: v = 9'd397;
      endcase
      return v;
    end
  endfunction

  // 2447 * j / 80
  function automatic logic [8:0] day_term(input logic [3:0] j);
    logic [8:0] v;
    begin
      unique case (j)
        4'd0:    v = 9'd0;
        4'd1:    v = 9'd30;
        4'd2:    v = 9'd61;
        4'd3:    v = 9'd91;
        4'd4:    v = 9'd122;
        4'd5:    v = 9'd152;
        4'd6:    v = 9'd183;
        4'd7:    v = 9'd214;
        4'd8:    v = 9'd244;
        4'd9:    v = 9'd275;
        4'd10:   v = 9'd305;
        4'd11:   v = 9'd336;
        4'd12:   v = 9'd367;
        4'd13:   v = 9'd397;
        4'd14:   v = 9'd428;
        default: v = 9'd458;
      endcase
      return v;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/cdau_divider.sv
// ----------------------------------------------------------------------------
// cdau_divider
// Division by a constant: reciprocal multiply estimate, then one correction
// step. Operands, estimate and quotient are registered in that order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdau_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [cdau_pkg::DIV_NW-1:0] dividend,
  input  wire logic [cdau_pkg::DIV_DW-1:0] divisor,
  input  wire logic [cdau_pkg::DIV_DW-1:0] recip,
  output logic      [cdau_pkg::DIV_QW-1:0] quot,
  output logic                             done
);
  import cdau_pkg::*;

  localparam int unsigned PW = DIV_NW + DIV_DW;
  localparam int unsigned BW = DIV_QW + DIV_DW;

  logic [DIV_NW-1:0] num_r, num_nxt;
  logic [DIV_DW-1:0] dsr_r, dsr_nxt;
  logic [DIV_DW-1:0] rcp_r, rcp_nxt;
  logic [DIV_QW-1:0] est_r, est_nxt;
  logic [DIV_QW-1:0] quot_r, quot_nxt;
  logic              est_pend_r, est_pend_nxt;
  logic              fix_pend_r, fix_pend_nxt;
  logic              done_r, done_nxt;
  logic [PW-1:0]     prod;
  logic [BW-1:0]     back;
  logic [BW-1:0]     rem;
  logic              ge;

  assign prod = PW'(num_r) * PW'(rcp_r);
  assign back = BW'(est_r) * BW'(dsr_r);
  // estimate never exceeds the true quotient, so no underflow here
  assign rem  = BW'(num_r) - back;
  assign ge   = (rem >= BW'(dsr_r));

  always_comb begin
    num_nxt      = num_r;
    dsr_nxt      = dsr_r;
    rcp_nxt      = rcp_r;
    est_nxt      = est_r;
    quot_nxt     = quot_r;
    est_pend_nxt = 1'b0;
    fix_pend_nxt = 1'b0;
    done_nxt     = 1'b0;
    if (start) begin
      num_nxt      = dividend;
      dsr_nxt      = divisor;
      rcp_nxt      = recip;
      est_pend_nxt = 1'b1;
    end else if (est_pend_r) begin
      est_nxt      = prod[DIV_RS+DIV_QW-1:DIV_RS];
      fix_pend_nxt = 1'b1;
    end else if (fix_pend_r) begin
      quot_nxt = est_r + DIV_QW'(ge);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    dsr_r  <= dsr_nxt;
    rcp_r  <= rcp_nxt;
    est_r  <= est_nxt;
    quot_r <= quot_nxt;
    if (!rst_n) begin
      est_pend_r <= 1'b0;
      fix_pend_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      est_pend_r <= est_pend_nxt;
      fix_pend_r <= fix_pend_nxt;
      done_r     <= done_nxt;
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

`default_nettype wire

### rtl/core/cdau_ctrl.sv
// ----------------------------------------------------------------------------
// cdau_ctrl
// Sequencer: steps the datapath through load or shift, then the summary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdau_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  input  wire logic                 in_action,
  output logic                      in_tready,
  input  wire logic                 out_tready,
  output logic                      out_tvalid,
  input  wire cdau_pkg::cdau_stat_t stat,
  output cdau_pkg::cdau_cmd_t       cmd
);
  import cdau_pkg::*;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   in_fire, out_free;

  assign in_fire  = in_tvalid && (state_r == ST_IDLE);
  assign out_free = !ovalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = (in_action == ACT_SHIFT) ? ST_SHIFT : ST_LOAD;
      ST_LOAD:   state_nxt = ST_JD_NOW;
      ST_SHIFT:  state_nxt = stat.shift_bad ? ST_JD_NOW : ST_N_GO;
      ST_N_GO:   state_nxt = ST_N_WAIT;
      ST_N_WAIT: if (stat.div_done) state_nxt = ST_I_GO;
      ST_I_GO:   state_nxt = ST_I_WAIT;
      ST_I_WAIT: if (stat.div_done) state_nxt = ST_J_GO;
      ST_J_GO:   state_nxt = ST_J_WAIT;
      ST_J_WAIT: if (stat.div_done) state_nxt = ST_JD_NOW;
      ST_JD_NOW: state_nxt = ST_JD_JAN;
      ST_JD_JAN: state_nxt = ST_JD_IN;
      ST_JD_IN:  state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.div_sel = DIV_N;
    ovalid_nxt = ovalid_r && !out_tready;
    unique case (state_r)
      ST_IDLE:   cmd.capture = in_fire;
      ST_LOAD:   cmd.load = 1'b1;
      ST_SHIFT:  cmd.shift = 1'b1;
      ST_N_GO:   begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_N;
      end
      ST_N_WAIT: cmd.take_n = stat.div_done;
      ST_I_GO:   begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_I;
      end
      ST_I_WAIT: cmd.take_i = stat.div_done;
      ST_J_GO:   begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_J;
      end
      ST_J_WAIT: cmd.take_j = stat.div_done;
      ST_JD_NOW: cmd.jd_now = 1'b1;
      ST_JD_JAN: cmd.jd_jan = 1'b1;
      ST_JD_IN:  cmd.jd_in = 1'b1;
      ST_EMIT:   begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          ovalid_nxt = 1'b1;
        end
      end
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;

endmodule

`default_nettype wire

### rtl/core/cdau_datapath.sv
// ----------------------------------------------------------------------------
// cdau_datapath
// Date registers, Julian day evaluation, inverse conversion and result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdau_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [cdau_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire cdau_pkg::cdau_cmd_t                 cmd,
  output cdau_pkg::cdau_stat_t                     stat,
  output logic      [cdau_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic      [1:0]                          out_tuser
);
  import cdau_pkg::*;

  // Julian day of a date, truncating division, a = -1 for Jan/Feb
  function automatic logic signed [25:0] to_jd(input logic [13:0] y,
                                               input logic [3:0]  m,
                                               input logic [4:0]  d);
    logic        early;
    logic [14:0] ya, yb;
    logic [25:0] p1;
    logic [26:0] p2;
    logic [7:0]  q;
    logic [9:0]  t3;
    logic [25:0] s;
    begin
      early = (m <= 4'd2);
      ya = {1'b0, y} + (early ? 15'd4799 : 15'd4800);
      yb = {1'b0, y} + (early ? 15'd4899 : 15'd4900);
      p1 = 26'(ya) * 26'd1461;
      p2 = 27'(yb) * 27'd5243;     // /100 by reciprocal, exact below 43690
      q  = p2[26:19];
      t3 = (10'(q) + {1'b0, q, 1'b0}) >> 2;
      s  = 26'(d) + 26'(p1[24:2]) + 26'(month_term(m)) - 26'(t3) - 26'd32075;
      return $signed(s);
    end
  endfunction

  // mod 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [22:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    begin
      s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
         + 6'(v[17:15]) + 6'(v[20:18]) + 6'(v[22:21]);
      s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
      s3 = 3'(s2[3]) + s2[2:0];
      return (s3 == 3'd7) ? 3'd0 : s3;
    end
  endfunction

  logic [22:0] off_r;
  logic [13:0] iy_r, cy_r;
  logic [3:0]  im_r, cm_r;
  logic [4:0]  id_r, cd_r;
  logic [1:0]  status_r;
  logic [22:0] l_r;
  logic [7:0]  n_r, i_r;
  logic [22:0] jd_r;
  logic [2:0]  wd_r;
  logic [8:0]  doy_r;
  logic [22:0] btw_r;
  logic [OUT_DATA_W-1:0] odata_r;
  logic [1:0]  ouser_r;

  logic signed [25:0] jd_cur, jd_sh, jd_jan, jd_in;
  logic               bad_shift, load_ok;
  logic [DIV_NW-1:0]  div_a;
  logic [DIV_DW-1:0]  div_b;
  logic [DIV_DW-1:0]  div_rcp;
  logic [DIV_QW-1:0]  div_q;
  logic               div_done;
  logic [3:0]         jj;
  logic               yr_wrap;
  logic [9:0]         kk;

  cdau_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .recip    (div_rcp),
    .quot     (div_q),
    .done     (div_done)
  );

  assign jd_cur    = to_jd(cy_r, cm_r, cd_r);
  assign jd_jan    = to_jd(cy_r, 4'd1, 5'd1);
  assign jd_in     = to_jd(iy_r, im_r, id_r);
  assign jd_sh     = jd_cur + 26'(signed'(off_r));
  assign bad_shift = (jd_sh < JD_MIN) || (jd_sh > JD_MAX);
  assign load_ok   = (id_r != 5'd0) && (im_r >= 4'd1) && (im_r <= 4'd12)
                  && (iy_r >= LOAD_YEAR_MIN) && (iy_r <= LOAD_YEAR_MAX);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_N: begin
        div_a   = DIV_NW'({l_r, 2'b00});
        div_b   = 21'd146097;
        div_rcp = RCP_N;
      end
      DIV_I: begin
        div_a   = (DIV_NW'(l_r) + 28'd1) * 28'd4000;
        div_b   = 21'd1461001;
        div_rcp = RCP_I;
      end
      DIV_J: begin
        div_a   = DIV_NW'(l_r) * 28'd80;
        div_b   = 21'd2447;
        div_rcp = RCP_J;
      end
      default: begin
        div_a   = '0;
        div_b   = 21'd1;
        div_rcp = '0;
      end
    endcase
  end

  assign jj      = div_q[3:0];
  assign yr_wrap = (jj >= 4'd11);
  assign kk      = l_r[9:0] - 10'(day_term(jj));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      off_r <= in_tdata[22:0];
      iy_r  <= in_tdata[36:23];
      im_r  <= in_tdata[40:37];
      id_r  <= in_tdata[45:41];
    end
    if (cmd.load) begin
      status_r <= load_ok ? STATUS_OK : STATUS_BAD_LOAD;
    end
    if (cmd.shift) begin
      status_r <= bad_shift ? STATUS_BAD_SHIFT : STATUS_OK;
      l_r      <= jd_sh[22:0] + 23'd68569;
    end
    if (cmd.take_n) begin
      n_r <= div_q;
      l_r <= l_r - 23'((25'(div_q) * 25'd146097 + 25'd3) >> 2);
    end
    if (cmd.take_i) begin
      i_r <= div_q;
      l_r <= l_r - 23'((19'(div_q) * 19'd1461) >> 2) + 23'd31;
    end
    if (cmd.jd_now) begin
      jd_r <= jd_cur[22:0];
      wd_r <= mod7(jd_cur[22:0]);
    end
    if (cmd.jd_jan) begin
      doy_r <= 9'(jd_r - jd_jan[22:0] + 23'd1);
    end
    if (cmd.jd_in) begin
      btw_r <= 23'(jd_in - signed'({3'b000, jd_r}));
    end
    if (cmd.emit) begin
      odata_r <= {7'd0, btw_r, doy_r, wd_r, jd_r, cd_r, cm_r, cy_r};
      ouser_r <= status_r;
    end
  end

  // current date: architectural state, reset to its documented value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cy_r <= RST_YEAR;
      cm_r <= RST_MONTH;
      cd_r <= RST_DAY;
    end else if (cmd.load && load_ok) begin
      cy_r <= iy_r;
      cm_r <= im_r;
      cd_r <= id_r;
    end else if (cmd.take_j) begin
      cy_r <= 14'(14'(n_r - 8'd49) * 14'd100 + 14'(i_r) + 14'(yr_wrap));
      cm_r <= jj + 4'd2 - (yr_wrap ? 4'd12 : 4'd0);
      cd_r <= kk[4:0];
    end
  end

  assign stat.shift_bad = bad_shift;
  assign stat.div_done  = div_done;
  assign out_tdata      = odata_r;
  assign out_tuser      = ouser_r;

endmodule

`default_nettype wire

### rtl/core/calendar_date_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_unit
// Kept Gregorian date with load, day shift and Julian day summary.
// ----------------------------------------------------------------------------
// One item at a time. A load or a refused shift goes straight to the Julian
// day summary; an accepted shift first runs three divisions by constants in
// the Julian-day-to-date conversion, each a reciprocal multiply and one
// correction step, on one shared divider. in_tready rises as the result
// register is loaded, even while that result still waits on out_tready.
// Each result carries the date after the step, its Julian day, weekday
// (0 Monday), day of year and the signed days to the input date; status
// in out_tuser.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_arithmetic_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // offset[22:0], in_year, in_month, in_day, pad
  input  wire logic        in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [87:0] out_tdata,  // year, month, day, julian_day, weekday,
                                       // day_of_year, days_between, pad
  output logic      [1:0]  out_tuser   // status
);
  import cdau_pkg::*;

  cdau_cmd_t  cmd;
  cdau_stat_t stat;

  cdau_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  cdau_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire
